[rtl/cdnw_pkg.sv]
// ----------------------------------------------------------------------------
// cdnw_pkg
// Shared constants and small helper functions for the Gregorian day number,
// weekday and week-of-month pipeline.
// ----------------------------------------------------------------------------
package cdnw_pkg;

    // Default year width and output field widths
    localparam int unsigned YEAR_BITS_DEF   = 12;
    localparam int unsigned MONTH_BITS      = 4;
    localparam int unsigned DAY_BITS        = 5;
    localparam int unsigned DAY_NUMBER_BITS = 20;
    localparam int unsigned WEEKDAY_BITS    = 3;
    localparam int unsigned WEEK_BITS       = 3;

    // Extra bits over the year width that the running day count needs (365 < 2**9)
    localparam int unsigned NUM_EXTRA_BITS  = 9;

    // Calendar constants
    localparam int unsigned BASE_YEAR       = 1980;
    localparam int unsigned DAYS_PER_YEAR   = 365;
    localparam int unsigned MONTHS_PER_YEAR = 12;
    localparam int unsigned FEBRUARY        = 2;
    localparam int unsigned DAYS_PER_WEEK   = 7;
    localparam int unsigned CENTURY         = 100;

    // Leap years among 1 .. BASE_YEAR-1
    localparam int unsigned BASE_LEAPS = (BASE_YEAR - 1) / 4 - (BASE_YEAR - 1) / 100
                                       + (BASE_YEAR - 1) / 400;

    // Exact y / 100 for any y below 2**16: (y * DIV100_MUL) >> DIV100_SHIFT
    localparam int unsigned DIV100_MUL   = 83887;
    localparam int unsigned DIV100_SHIFT = 23;
    localparam int unsigned MUL_BITS     = 17;

    // Weekday of day count zero: weekday(n) = (n + 1) mod 7
    localparam int unsigned WEEKDAY_SHIFT = 1;

    // Weekday reported for an invalid date (weekday of day count zero)
    localparam logic [WEEKDAY_BITS-1:0] INVALID_WEEKDAY = 3'd1;

    // Days in the year before the first of month m, 0 for a month out of range
    function automatic logic [8:0] days_before_month(input logic [MONTH_BITS-1:0] m);
        logic [8:0] res;
        begin
            case (m)
                4'd1:    res = 9'd0;
                4'd2:    res = 9'd31;
                4'd3:    res = 9'd59;
                4'd4:    res = 9'd90;
                4'd5:    res = 9'd120;
                4'd6:    res = 9'd151;
                4'd7:    res = 9'd181;
                4'd8:    res = 9'd212;
                4'd9:    res = 9'd243;
                4'd10:   res = 9'd273;
                4'd11:   res = 9'd304;
                4'd12:   res = 9'd334;
                default: res = 9'd0;
            endcase
            return res;
        end
    endfunction

    // Remainder modulo 7 of a 6-bit value by four compare-and-subtract steps
    function automatic logic [WEEKDAY_BITS-1:0] mod7_small(input logic [5:0] x);
        logic [5:0] r;
        begin
            r = x;
            if (r >= 6'd56) r = r - 6'd56;
            if (r >= 6'd28) r = r - 6'd28;
            if (r >= 6'd14) r = r - 6'd14;
            if (r >= 6'd7)  r = r - 6'd7;
            return r[WEEKDAY_BITS-1:0];
        end
    endfunction

    // Week of month for day d when day 1 is on weekday f: 1 for day zero, else
    // ceil((d + f) / 7), with x / 7 done as (x * 37) >> 8 for x below 56
    function automatic logic [WEEK_BITS-1:0] week_index(input logic [DAY_BITS-1:0] d,
                                                        input logic [WEEKDAY_BITS-1:0] f);
        logic [5:0]  x;
        logic [10:0] p;
        logic [WEEK_BITS-1:0] res;
        begin
            x = 6'(d) + 6'(f) + 6'(DAYS_PER_WEEK - 1);
            p = 11'(x) * 11'd37;
            if (d == '0)
                res = 3'd1;
            else
                res = p[10:8];
            return res;
        end
    endfunction

endpackage

[rtl/calendar_day_number_weekday.sv]
// ----------------------------------------------------------------------------
// calendar_day_number_weekday
// Gregorian date to 1-based day number since 1980-01-01, weekday and week of
// the month, as a seven-stage pipeline.
// ----------------------------------------------------------------------------
// Usage: the block takes one date in every clock cycle and busy stays low.
// Each item's result shows on the result ports with done high for exactly one
// cycle, once the item has passed through every stage; the receiver takes it
// while done is high. Results leave in the order the items came in.
// The receiver cannot hold results off and need not: results leave at the
// rate items enter. The latency is set by the pipeline depth: one stage
// for the divide-by-100 reciprocal multiply, one for the leap count, one for
// the wide sum, one for the day offsets, two for the modulo-7 reduction and
// one for the week of the month. Years below 1980, months outside 1..12 and a
// day of zero give date_valid low, day_number zero and weekday 1.
// ----------------------------------------------------------------------------
module calendar_day_number_weekday #(
    parameter int unsigned YEAR_BITS = cdnw_pkg::YEAR_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [YEAR_BITS-1:0]                   year,
    input  logic [cdnw_pkg::MONTH_BITS-1:0]        month,
    input  logic [cdnw_pkg::DAY_BITS-1:0]          day,
    output logic                                   done,
    output logic                                   date_valid,
    output logic [cdnw_pkg::DAY_NUMBER_BITS-1:0]   day_number,
    output logic [cdnw_pkg::WEEKDAY_BITS-1:0]      weekday,
    output logic [cdnw_pkg::WEEK_BITS-1:0]         week_of_month
);

    localparam int unsigned DN_BITS   = YEAR_BITS + cdnw_pkg::NUM_EXTRA_BITS;
    localparam int unsigned PROD_BITS = YEAR_BITS + cdnw_pkg::MUL_BITS;
    localparam int unsigned Q_BITS    = PROD_BITS - cdnw_pkg::DIV100_SHIFT;
    localparam int unsigned FOLD_BITS = DN_BITS + 1;
    localparam int unsigned GROUPS    = (FOLD_BITS + 2) / 3;
    localparam int unsigned R_BITS    = 7;

    localparam int unsigned MB = cdnw_pkg::MONTH_BITS;
    localparam int unsigned DB = cdnw_pkg::DAY_BITS;
    localparam int unsigned WB = cdnw_pkg::WEEKDAY_BITS;

    // Sum of the octal digits of a value: congruent to it modulo 7
    function automatic logic [5:0] fold_octal(input logic [FOLD_BITS-1:0] v);
        logic [GROUPS*3-1:0] pad;
        logic [5:0]          acc;
        begin
            pad = (GROUPS*3)'(v);
            acc = '0;
            for (int i = 0; i < GROUPS; i++)
            begin
                acc = acc + 6'(pad[3*i +: 3]);
            end
            return acc;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Pipeline valid bits
    // ------------------------------------------------------------------------
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic s5_vld_reg, s6_vld_reg, s7_vld_reg;

    // Stage 1: range checks, reciprocal multiply, year days
    logic [YEAR_BITS-1:0] s1_y_reg;
    logic [MB-1:0]        s1_m_reg;
    logic [DB-1:0]        s1_d_reg;
    logic                 s1_ymok_reg;
    logic [PROD_BITS-1:0] s1_prod_reg;
    logic [DN_BITS-1:0]   s1_t365_reg;
    logic [8:0]           s1_dbm_reg;
    logic                 s1_ymok_next;
    logic [YEAR_BITS-1:0] s1_t;
    logic [PROD_BITS-1:0] s1_prod_next;
    logic [DN_BITS-1:0]   s1_t365_next;

    // Stage 2: leap count and leap-day adjust
    logic [DB-1:0]        s2_d_reg;
    logic                 s2_ymok_reg;
    logic [DN_BITS-1:0]   s2_t365_reg;
    logic [8:0]           s2_dbm_reg;
    logic [YEAR_BITS-1:0] s2_leaps_reg;
    logic                 s2_adj_reg;
    logic [Q_BITS-1:0]    s2_q;
    logic [YEAR_BITS-1:0] s2_qy;
    logic [YEAR_BITS-1:0] s2_rem_full;
    logic [R_BITS-1:0]    s2_r;
    logic [YEAR_BITS-1:0] s2_qm1;
    logic [YEAR_BITS-1:0] s2_ym1;
    logic                 s2_leap;
    logic [YEAR_BITS-1:0] s2_leaps_next;
    logic                 s2_adj_next;

    // Stage 3: day number of day 1 of the month, minus one
    logic [DB-1:0]        s3_d_reg;
    logic                 s3_ymok_reg;
    logic [DN_BITS-1:0]   s3_base_reg;
    logic [DN_BITS-1:0]   s3_base_next;

    // Stage 4: day number and weekday offsets
    logic [DB-1:0]        s4_d_reg;
    logic                 s4_ymok_reg;
    logic                 s4_ok_reg;
    logic [DN_BITS-1:0]   s4_num_reg;
    logic [FOLD_BITS-1:0] s4_wn_reg;
    logic [FOLD_BITS-1:0] s4_fn_reg;

    // Stage 5: octal digit sums
    logic [DB-1:0]        s5_d_reg;
    logic                 s5_ymok_reg;
    logic                 s5_ok_reg;
    logic [DN_BITS-1:0]   s5_num_reg;
    logic [5:0]           s5_wsum_reg;
    logic [5:0]           s5_fsum_reg;

    // Stage 6: final weekdays
    logic [DB-1:0]        s6_d_reg;
    logic                 s6_ok_reg;
    logic [DN_BITS-1:0]   s6_num_reg;
    logic [WB-1:0]        s6_wd_reg;
    logic [WB-1:0]        s6_first_reg;
    logic [WB-1:0]        s6_wd_next;
    logic [WB-1:0]        s6_first_next;

    // Stage 7: result registers
    logic                                 s7_ok_reg;
    logic [cdnw_pkg::DAY_NUMBER_BITS-1:0] s7_num_reg;
    logic [WB-1:0]                        s7_wd_reg;
    logic [cdnw_pkg::WEEK_BITS-1:0]       s7_week_reg;

    // ------------------------------------------------------------------------
    // Stage 1 logic
    // ------------------------------------------------------------------------
    always_comb
    begin
        s1_ymok_next = (year >= YEAR_BITS'(cdnw_pkg::BASE_YEAR))
                     && (month >= MB'(1))
                     && (month <= MB'(cdnw_pkg::MONTHS_PER_YEAR));
        s1_t         = year - YEAR_BITS'(cdnw_pkg::BASE_YEAR);
        s1_prod_next = PROD_BITS'(year) * PROD_BITS'(cdnw_pkg::DIV100_MUL);
        s1_t365_next = DN_BITS'(s1_t) * DN_BITS'(cdnw_pkg::DAYS_PER_YEAR);
    end

    // ------------------------------------------------------------------------
    // Stage 2 logic: y / 100 from the product, leaps among 1 .. y-1
    // ------------------------------------------------------------------------
    always_comb
    begin
        s2_q          = s1_prod_reg[PROD_BITS-1 -: Q_BITS];
        s2_qy         = YEAR_BITS'(s2_q);
        s2_rem_full   = s1_y_reg - s2_qy * YEAR_BITS'(cdnw_pkg::CENTURY);
        s2_r          = s2_rem_full[R_BITS-1:0];
        s2_leap       = (s1_y_reg[1:0] == 2'd0) && ((s2_r != '0) || (s2_q[1:0] == 2'd0));
        // (y-1)/100 drops by one when y is a whole century
        s2_qm1        = s2_qy - YEAR_BITS'(s2_r == '0);
        s2_ym1        = s1_y_reg - YEAR_BITS'(1);
        s2_leaps_next = (s2_ym1 >> 2) - s2_qm1 + (s2_qm1 >> 2);
        s2_adj_next   = s2_leap && (s1_m_reg > MB'(cdnw_pkg::FEBRUARY));
    end

    // ------------------------------------------------------------------------
    // Stage 3 logic: sum the year, leap and month offsets
    // ------------------------------------------------------------------------
    always_comb
    begin
        s3_base_next = s2_t365_reg + DN_BITS'(s2_leaps_reg)
                     - DN_BITS'(cdnw_pkg::BASE_LEAPS)
                     + DN_BITS'(s2_dbm_reg) + DN_BITS'(s2_adj_reg);
    end

    // ------------------------------------------------------------------------
    // Stage 6 logic: reduce the digit sums and apply invalid-date weekdays
    // ------------------------------------------------------------------------
    always_comb
    begin
        s6_wd_next    = s5_ok_reg ? cdnw_pkg::mod7_small(s5_wsum_reg)
                                  : cdnw_pkg::INVALID_WEEKDAY;
        s6_first_next = s5_ymok_reg ? cdnw_pkg::mod7_small(s5_fsum_reg)
                                    : cdnw_pkg::INVALID_WEEKDAY;
    end

    // ------------------------------------------------------------------------
    // Valid bits: advance one stage a cycle
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers: load each stage behind its valid bit
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_y_reg    <= year;
            s1_m_reg    <= month;
            s1_d_reg    <= day;
            s1_ymok_reg <= s1_ymok_next;
            s1_prod_reg <= s1_prod_next;
            s1_t365_reg <= s1_t365_next;
            s1_dbm_reg  <= cdnw_pkg::days_before_month(month);
        end
        if (s1_vld_reg)
        begin
            s2_d_reg     <= s1_d_reg;
            s2_ymok_reg  <= s1_ymok_reg;
            s2_t365_reg  <= s1_t365_reg;
            s2_dbm_reg   <= s1_dbm_reg;
            s2_leaps_reg <= s2_leaps_next;
            s2_adj_reg   <= s2_adj_next;
        end
        if (s2_vld_reg)
        begin
            s3_d_reg    <= s2_d_reg;
            s3_ymok_reg <= s2_ymok_reg;
            s3_base_reg <= s3_base_next;
        end
        if (s3_vld_reg)
        begin
            s4_d_reg    <= s3_d_reg;
            s4_ymok_reg <= s3_ymok_reg;
            s4_ok_reg   <= s3_ymok_reg && (s3_d_reg != '0);
            s4_num_reg  <= s3_base_reg + DN_BITS'(s3_d_reg);
            s4_wn_reg   <= FOLD_BITS'(s3_base_reg) + FOLD_BITS'(s3_d_reg)
                         + FOLD_BITS'(cdnw_pkg::WEEKDAY_SHIFT);
            s4_fn_reg   <= FOLD_BITS'(s3_base_reg) + FOLD_BITS'(1)
                         + FOLD_BITS'(cdnw_pkg::WEEKDAY_SHIFT);
        end
        if (s4_vld_reg)
        begin
            s5_d_reg    <= s4_d_reg;
            s5_ymok_reg <= s4_ymok_reg;
            s5_ok_reg   <= s4_ok_reg;
            s5_num_reg  <= s4_num_reg;
            s5_wsum_reg <= fold_octal(s4_wn_reg);
            s5_fsum_reg <= fold_octal(s4_fn_reg);
        end
        if (s5_vld_reg)
        begin
            s6_d_reg     <= s5_d_reg;
            s6_ok_reg    <= s5_ok_reg;
            s6_num_reg   <= s5_num_reg;
            s6_wd_reg    <= s6_wd_next;
            s6_first_reg <= s6_first_next;
        end
        if (s6_vld_reg)
        begin
            s7_ok_reg   <= s6_ok_reg;
            s7_num_reg  <= s6_ok_reg ? s6_num_reg[cdnw_pkg::DAY_NUMBER_BITS-1:0] : '0;
            s7_wd_reg   <= s6_wd_reg;
            s7_week_reg <= cdnw_pkg::week_index(s6_d_reg, s6_first_reg);
        end
    end

    // ------------------------------------------------------------------------
    // Drive the ports: one item enters every cycle
    // ------------------------------------------------------------------------
    assign busy          = 1'b0;
    assign done          = s7_vld_reg;
    assign date_valid    = s7_ok_reg;
    assign day_number    = s7_num_reg;
    assign weekday       = s7_wd_reg;
    assign week_of_month = s7_week_reg;

endmodule

[tb/sv/calendar_day_number_weekday_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_day_number_weekday_test
// Drives dates into the day number / weekday / week-of-month pipeline with
// random idle gaps and checks every result against a behavioral predictor or
// a typed row. A short corner-date table runs first, then 1650 random dates.
// ----------------------------------------------------------------------------
module calendar_day_number_weekday_test;

    import cdnw_pkg::*;

    localparam int unsigned YEAR_W       = YEAR_BITS_DEF;
    localparam int unsigned PIPE_LATENCY = 7;
    localparam int unsigned RANDOM_DATES = 1650;
    localparam int unsigned PRINT_LIMIT  = 50;
    localparam int unsigned EPOCH_YEAR   = 1980;
    localparam int unsigned MAX_YEAR     = (1 << YEAR_W) - 1;

    typedef struct packed {
        logic                       date_valid;
        logic [DAY_NUMBER_BITS-1:0] day_number;
        logic [WEEKDAY_BITS-1:0]    weekday;
        logic [WEEK_BITS-1:0]       week_of_month;
    } date_result_t;

    typedef struct {
        int unsigned  y;
        int unsigned  m;
        int unsigned  d;
        bit           typed;
        date_result_t want;
    } date_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [YEAR_W-1:0]          year;
    logic [MONTH_BITS-1:0]      month;
    logic [DAY_BITS-1:0]        day;
    logic                       done;
    logic                       date_valid;
    logic [DAY_NUMBER_BITS-1:0] day_number;
    logic [WEEKDAY_BITS-1:0]    weekday;
    logic [WEEK_BITS-1:0]       week_of_month;

    // Cumulative days before the first of each month in a common year
    int unsigned  month_start [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    date_result_t pending_results [$];
    date_row_t    directed_rows [$];

    // Typed expectation for the item currently on the inputs, if any
    bit           next_typed;
    date_result_t next_want;

    int unsigned  mismatch_count;
    int unsigned  dates_taken;
    int unsigned  valid_results;
    int unsigned  rejected_results;

    calendar_day_number_weekday u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .year          (year),
        .month         (month),
        .day           (day),
        .done          (done),
        .date_valid    (date_valid),
        .day_number    (day_number),
        .weekday       (weekday),
        .week_of_month (week_of_month)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gregorian leap rule
    function automatic bit is_leap(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // Leap years among 1..n
    function automatic int unsigned leaps_through(int unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // Full 1-based day count since the epoch, 0 for an out-of-range date
    function automatic int unsigned days_from_epoch(int unsigned y, int unsigned m,
                                                    int unsigned d);
        int unsigned n;
        if (y < EPOCH_YEAR || m < 1 || m > 12 || d < 1 || d > 31)
            return 0;
        n = d + month_start[m-1];
        if (m > 2 && is_leap(y))
            n = n + 1;
        n = n + (y - EPOCH_YEAR) * 365 + leaps_through(y - 1) - leaps_through(EPOCH_YEAR - 1);
        return n;
    endfunction

    // Expected result for one date
    function automatic date_result_t predict_date(int unsigned y, int unsigned m,
                                                  int unsigned d);
        date_result_t res;
        int unsigned  n;
        int unsigned  first_wd;
        int unsigned  first_week_end;
        int unsigned  wk;
        int unsigned  wd;
        n              = days_from_epoch(y, m, d);
        first_wd       = (days_from_epoch(y, m, 1) + 1) % 7;
        first_week_end = 7 - first_wd;
        if (d <= first_week_end)
            wk = 1;
        else
            wk = (d - (first_week_end + 1)) / 7 + 2;
        wd                = (n + 1) % 7;
        res.date_valid    = (n != 0);
        res.day_number    = n[DAY_NUMBER_BITS-1:0];
        res.weekday       = wd[WEEKDAY_BITS-1:0];
        res.week_of_month = wk[WEEK_BITS-1:0];
        return res;
    endfunction

    // Count a mismatch and print it while under the print cap
    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // Queue one row of the directed table
    task automatic add_row(int unsigned y, int unsigned m, int unsigned d, bit typed,
                           int unsigned v, int unsigned dn, int unsigned wd, int unsigned wk);
        date_row_t row;
        row.y                  = y;
        row.m                  = m;
        row.d                  = d;
        row.typed              = typed;
        row.want.date_valid    = v[0];
        row.want.day_number    = dn[DAY_NUMBER_BITS-1:0];
        row.want.weekday       = wd[WEEKDAY_BITS-1:0];
        row.want.week_of_month = wk[WEEK_BITS-1:0];
        directed_rows.push_back(row);
    endtask

    // Present one date and hold it until the block takes it
    task automatic send_date(int unsigned y, int unsigned m, int unsigned d, bit typed,
                             date_result_t want);
        @(negedge clk);
        start      <= 1'b1;
        year       <= y[YEAR_W-1:0];
        month      <= m[MONTH_BITS-1:0];
        day        <= d[DAY_BITS-1:0];
        next_typed  = typed;
        next_want   = want;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // Drop start for a number of cycles, with junk on the date fields
    task automatic idle_for(int unsigned cycles);
        if (cycles == 0)
            return;
        @(negedge clk);
        start <= 1'b0;
        year  <= YEAR_W'($urandom);
        month <= MONTH_BITS'($urandom);
        day   <= DAY_BITS'($urandom);
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Mostly back-to-back or short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Check each result as it leaves and record each item as it is taken
    always @(posedge clk)
    begin : watch_results
        date_result_t got;
        date_result_t want;
        if (rst_n === 1'b1)
        begin
            if (done === 1'b1)
            begin
                got = '{date_valid, day_number, weekday, week_of_month};
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with no date outstanding: %0d %0d %0d %0d",
                                              got.date_valid, got.day_number, got.weekday,
                                              got.week_of_month));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.date_valid !== want.date_valid)
                        report_mismatch($sformatf("date_valid got %0d expected %0d",
                                                  got.date_valid, want.date_valid));
                    if (got.day_number !== want.day_number)
                        report_mismatch($sformatf("day_number got %0d expected %0d",
                                                  got.day_number, want.day_number));
                    if (got.weekday !== want.weekday)
                        report_mismatch($sformatf("weekday got %0d expected %0d",
                                                  got.weekday, want.weekday));
                    if (got.week_of_month !== want.week_of_month)
                        report_mismatch($sformatf("week_of_month got %0d expected %0d",
                                                  got.week_of_month, want.week_of_month));
                    if (want.date_valid)
                        valid_results++;
                    else
                        rejected_results++;
                end
            end
            else if (done !== 1'b0)
            begin
                report_mismatch("done is unknown");
            end

            if (start === 1'b1 && busy === 1'b0)
            begin
                if (next_typed)
                    pending_results.push_back(next_want);
                else
                    pending_results.push_back(predict_date(year, month, day));
                dates_taken++;
            end
        end
    end

    // Main sequence
    initial
    begin : run_dates
        int unsigned  y;
        int unsigned  m;
        int unsigned  d;
        int unsigned  len;
        int unsigned  pick;
        int unsigned  burst_left;
        date_result_t none;

        none             = '0;
        next_typed       = 1'b0;
        next_want        = '0;
        mismatch_count   = 0;
        dates_taken      = 0;
        valid_results    = 0;
        rejected_results = 0;
        burst_left       = 0;

        rst_n = 1'b0;
        start = 1'b0;
        year  = '0;
        month = '0;
        day   = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Epoch and a month end with plain answers
        add_row(1980,  1,  1, 1, 1,  1, 2, 1);
        add_row(1980,  1, 31, 1, 1, 31, 4, 5);
        // Rejected dates: weekday 1, week counted as if day 1 were a Monday
        add_row(   0,  0,  0, 1, 0,  0, 1, 1);
        add_row(1979, 12, 31, 1, 0,  0, 1, 5);
        add_row(1980,  0,  1, 1, 0,  0, 1, 1);
        add_row(2000, 13, 15, 1, 0,  0, 1, 3);
        add_row(MAX_YEAR, 15, 31, 1, 0, 0, 1, 5);
        // Day zero in a valid month stays in week 1
        add_row(1980,  1,  0, 1, 0,  0, 1, 1);
        add_row(1980, 12,  0, 1, 0,  0, 1, 1);
        // Leap rule, century years, days past the month end, wide years
        add_row(1980,  2, 29, 0, 0, 0, 0, 0);
        add_row(1980,  3,  1, 0, 0, 0, 0, 0);
        add_row(1980, 12, 31, 0, 0, 0, 0, 0);
        add_row(1981,  1,  1, 0, 0, 0, 0, 0);
        add_row(1981,  2, 31, 0, 0, 0, 0, 0);
        add_row(2000,  2, 29, 0, 0, 0, 0, 0);
        add_row(2000,  3,  1, 0, 0, 0, 0, 0);
        add_row(2100,  2, 29, 0, 0, 0, 0, 0);
        add_row(2100,  3,  1, 0, 0, 0, 0, 0);
        add_row(2400,  3,  1, 0, 0, 0, 0, 0);
        add_row(2024,  6, 30, 0, 0, 0, 0, 0);
        add_row(2047, 15,  0, 0, 0, 0, 0, 0);
        add_row(3968,  8, 16, 0, 0, 0, 0, 0);
        add_row(MAX_YEAR,  1,  1, 0, 0, 0, 0, 0);
        add_row(MAX_YEAR, 12, 31, 0, 0, 0, 0, 0);

        foreach (directed_rows[i])
        begin
            send_date(directed_rows[i].y, directed_rows[i].m, directed_rows[i].d,
                      directed_rows[i].typed, directed_rows[i].want);
            idle_for(pick_gap());
        end

        // Random dates: mostly well-formed, some out of range, some raw bits
        repeat (RANDOM_DATES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                case ($urandom_range(0, 2))
                    0:       y = $urandom_range(EPOCH_YEAR, 2100);
                    1:       y = 100 * $urandom_range(20, 40) + $urandom_range(0, 2) - 1;
                    default: y = $urandom_range(EPOCH_YEAR, MAX_YEAR);
                endcase
                m = $urandom_range(1, 12);
                if (m == 2)
                    len = is_leap(y) ? 29 : 28;
                else if (m == 4 || m == 6 || m == 9 || m == 11)
                    len = 30;
                else
                    len = 31;
                case ($urandom_range(0, 9))
                    0, 1, 2: d = len - $urandom_range(0, 2);
                    3:       d = $urandom_range(1, 31);
                    default: d = $urandom_range(1, len);
                endcase
            end
            else if (pick < 85)
            begin
                y = $urandom_range(EPOCH_YEAR, MAX_YEAR);
                m = $urandom_range(1, 12);
                d = $urandom_range(1, 31);
                case ($urandom_range(0, 2))
                    0:       y = $urandom_range(0, EPOCH_YEAR - 1);
                    1:       m = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
                    default: d = 0;
                endcase
            end
            else
            begin
                y = $urandom_range(0, MAX_YEAR);
                m = $urandom_range(0, 15);
                d = $urandom_range(0, 31);
            end

            send_date(y, m, d, 1'b0, none);

            // Hold back-to-back bursts now and then
            if (burst_left == 0 && $urandom_range(0, 99) < 5)
                burst_left = $urandom_range(16, 48);
            if (burst_left != 0)
                burst_left--;
            else
                idle_for(pick_gap());
        end

        // Drain the pipeline
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 8) @(posedge clk);

        $display("Checked %0d dates: %0d directed, %0d random", dates_taken,
                 directed_rows.size(), dates_taken - directed_rows.size());
        $display("Results: %0d valid dates, %0d rejected, %0d mismatches", valid_results,
                 rejected_results, mismatch_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d results still outstanding", pending_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
